// ===== rtl/crpe_pkg.sv =====
package crpe_pkg;

  // Point store geometry
  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int TOT_W      = IDX_W + 1;

  // Coordinate and arithmetic widths
  localparam int COORD_W    = 32;
  localparam int PT_W       = 3 * COORD_W;
  localparam int SQ_W       = 68;
  localparam int ROOT_W     = 34;
  localparam int REM_W      = 36;
  localparam int OPEN_W     = 48;
  localparam int LEN_W      = 49;
  localparam int TS_W       = 64;
  localparam int PROD_W     = TS_W + TOT_W;
  localparam int FRAC_W     = 16;
  localparam int MOD_W      = TOT_W + FRAC_W;
  localparam int H_W        = 40;
  localparam int MP_W       = H_W + FRAC_W + 1;

  // Sequencer lengths
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = PROD_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int NRD        = 5;

  // Config port
  localparam int ADDR_W     = 3;
  localparam logic REG_SPEED  = 1'b0;
  localparam logic REG_CLOSED = 1'b1;
  localparam logic [31:0] SPEED_RESET = 32'h0001_0000;

  // Opcodes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_EVAL   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Hermite evaluation phases
  localparam logic [1:0] PH_A3  = 2'd0;
  localparam logic [1:0] PH_A2  = 2'd1;
  localparam logic [1:0] PH_OUT = 2'd2;

  // Read slots for the segment's points
  localparam logic [2:0] RS_P0  = 3'd0;
  localparam logic [2:0] RS_P1  = 3'd1;
  localparam logic [2:0] RS_PV  = 3'd2;
  localparam logic [2:0] RS_NX1 = 3'd3;
  localparam logic [2:0] RS_PV1 = 3'd4;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [31:0]        eval_time;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               empty_path;
  } out_res_t;

  typedef struct packed {
    logic       latch_in;
    logic       sq_clr;
    logic       sq_step;
    logic       chord_sel_first;
    logic [1:0] axis;
    logic       sqrt_step;
    logic       acc_chord;
    logic       wr_point;
    logic       clear_pts;
    logic       len_load;
    logic       mul_ts;
    logic       mul_n;
    logic       div_step;
    logic       idx_calc;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       cap_en;
    logic [2:0] cap_sel;
    logic       herm_step;
    logic [1:0] phase;
    logic       out_load;
    logic       out_empty;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       total_zero;
    logic       total_full;
    logic       len_zero;
  } sts_t;

endpackage

// ===== rtl/crpe_ctrl.sv =====
module crpe_ctrl import crpe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  logic closed_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_SQ   = 4'd2;
  localparam logic [3:0] S_SQRT = 4'd3;
  localparam logic [3:0] S_ACC  = 4'd4;
  localparam logic [3:0] S_LEN  = 4'd5;
  localparam logic [3:0] S_TS   = 4'd6;
  localparam logic [3:0] S_PN   = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_IDX  = 4'd9;
  localparam logic [3:0] S_RD   = 4'd10;
  localparam logic [3:0] S_HERM = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       axis_q, axis_d;
  logic [1:0]       phase_q, phase_d;
  logic             empty_q, empty_d;
  logic             out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // Sequence one request at a time
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    cnt_d   = cnt_q;
    axis_d  = axis_q;
    phase_d = phase_q;
    empty_d = empty_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_DISP;
        end
      end
      S_DISP: begin
        cnt_d = '0;
        case (sts_i.op)
          OP_APPEND: begin
            if (sts_i.total_full) begin
              state_d = S_IDLE;
            end else if (sts_i.total_zero) begin
              cmd_o.wr_point = 1'b1;
              state_d        = S_IDLE;
            end else begin
              cmd_o.sq_clr = 1'b1;
              state_d      = S_SQ;
            end
          end
          OP_EVAL: begin
            if (sts_i.total_zero) begin
              empty_d = 1'b1;
              state_d = S_DONE;
            end else if (closed_i) begin
              cmd_o.sq_clr = 1'b1;
              state_d      = S_SQ;
            end else begin
              state_d = S_LEN;
            end
          end
          OP_CLEAR: begin
            cmd_o.clear_pts = 1'b1;
            state_d         = S_IDLE;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SQ: begin
        cmd_o.sq_step         = 1'b1;
        cmd_o.axis            = cnt_q[1:0];
        cmd_o.chord_sel_first = (sts_i.op == OP_EVAL);
        if (cnt_q == CNT_W'(2)) begin
          cnt_d   = '0;
          state_d = S_SQRT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = (sts_i.op == OP_EVAL) ? S_LEN : S_ACC;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_ACC: begin
        cmd_o.acc_chord = 1'b1;
        cmd_o.wr_point  = 1'b1;
        state_d         = S_IDLE;
      end
      S_LEN: begin
        cmd_o.len_load = 1'b1;
        state_d        = S_TS;
      end
      S_TS: begin
        if (sts_i.len_zero) begin
          empty_d = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.mul_ts = 1'b1;
          state_d      = S_PN;
        end
      end
      S_PN: begin
        cmd_o.mul_n = 1'b1;
        cnt_d       = '0;
        state_d     = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_IDX;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDX: begin
        cmd_o.idx_calc = 1'b1;
        cnt_d          = '0;
        state_d        = S_RD;
      end
      S_RD: begin
        // Issue one read per cycle, capture each in the cycle after its read
        cmd_o.rd_en   = (cnt_q < CNT_W'(NRD));
        cmd_o.rd_sel  = (cnt_q < CNT_W'(NRD)) ? cnt_q[2:0] : RS_P0;
        cmd_o.cap_en  = (cnt_q != '0);
        cmd_o.cap_sel = cnt_q[2:0] - 3'd1;
        if (cnt_q == CNT_W'(NRD)) begin
          axis_d  = 2'd0;
          phase_d = PH_A3;
          state_d = S_HERM;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_HERM: begin
        cmd_o.herm_step = 1'b1;
        cmd_o.axis      = axis_q;
        cmd_o.phase     = phase_q;
        if (phase_q == PH_OUT) begin
          phase_d = PH_A3;
          axis_d  = axis_q + 2'd1;
          if (axis_q == 2'd2) begin
            empty_d = 1'b0;
            state_d = S_DONE;
          end
        end else begin
          phase_d = phase_q + 2'd1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_empty = empty_q;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the result until the receiver takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      axis_q      <= '0;
      phase_q     <= PH_A3;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      axis_q      <= axis_d;
      phase_q     <= phase_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_DISP))
    else $error("accepted request not dispatched");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result raised outside done state");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q < CNT_W'(DIV_STEPS)))
    else $error("divider step count overrun");
`endif

endmodule

// ===== rtl/crpe_dp.sv =====
module crpe_dp import crpe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  in_req_t     in_req_i,
  input  logic [31:0] speed_i,
  input  logic        closed_i,
  output out_res_t    out_res_o
);

  // Control state
  logic [TOT_W-1:0]  total_q;
  logic [OPEN_W-1:0] open_q;

  // Payload registers
  in_req_t           in_q;
  logic [PT_W-1:0]   first_q, last_q;
  logic [SQ_W-1:0]   sumsq_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [LEN_W-1:0]  len_q;
  logic [TS_W-1:0]   ts_q;
  logic [PROD_W-1:0] prod_q;
  logic [LEN_W-1:0]  drem_q;
  logic [MOD_W-1:0]  qm_q;
  logic [FRAC_W-1:0] f_q;
  logic [IDX_W-1:0]  addr_q [NRD];
  logic [PT_W-1:0]   rdata_q;
  logic [PT_W-1:0]   pts_q [NRD];
  logic signed [H_W-1:0] h_q;
  logic [31:0]       res_q [3];
  out_res_t          out_q;
  logic [PT_W-1:0]   mem [MAX_POINTS];

  logic [PT_W-1:0] in_pt;
  assign in_pt = {in_q.point_z, in_q.point_y, in_q.point_x};

  assign sts_o.op         = in_q.opcode;
  assign sts_o.total_zero = (total_q == '0);
  assign sts_o.total_full = (total_q >= TOT_W'(MAX_POINTS));
  assign sts_o.len_zero   = (len_q == '0);
  assign out_res_o        = out_q;

  // Squared chord component
  logic [PT_W-1:0]    b_pt;
  logic [31:0]        a_ax, b_ax;
  logic signed [32:0] diff;
  logic [32:0]        mag;
  logic [65:0]        sq;
  assign b_pt = cmd_i.chord_sel_first ? first_q : in_pt;
  assign a_ax = last_q[32*cmd_i.axis +: 32];
  assign b_ax = b_pt[32*cmd_i.axis +: 32];
  assign diff = $signed({b_ax[31], b_ax}) - $signed({a_ax[31], a_ax});
  assign mag  = diff[32] ? 33'(-diff) : 33'(diff);
  assign sq   = 66'(mag) * 66'(mag);

  // Square root, one result bit per step
  logic [REM_W+1:0] rtry, rtrial;
  assign rtry   = {rem_q, sumsq_q[SQ_W-1 -: 2]};
  assign rtrial = {2'b00, root_q, 2'b01};

  // Time division, one quotient bit per step
  logic [LEN_W:0]   dtry;
  logic             dq;
  logic [LEN_W-1:0] drem_n;
  logic [MOD_W:0]   qtry;
  logic [MOD_W-1:0] modulus;
  assign dtry    = {drem_q, prod_q[PROD_W-1]};
  assign dq      = (dtry >= {1'b0, len_q});
  assign drem_n  = dq ? LEN_W'(dtry - {1'b0, len_q}) : dtry[LEN_W-1:0];
  assign qtry    = {qm_q, dq};
  assign modulus = {total_q, {FRAC_W{1'b0}}};

  // Neighbor indices of the segment
  logic [IDX_W-1:0] seg, last_idx, nx, pv, s1, nx1, pv1;
  logic [TOT_W-1:0] tot_m1, seg_p1, s1_p1;
  logic             seg_nx;
  assign seg      = qm_q[FRAC_W +: IDX_W];
  assign tot_m1   = total_q - 1'b1;
  assign last_idx = tot_m1[IDX_W-1:0];
  assign seg_p1   = {1'b0, seg} + 1'b1;
  assign seg_nx   = (seg_p1 < total_q);
  assign nx       = seg_nx ? seg_p1[IDX_W-1:0] : (closed_i ? '0 : last_idx);
  assign pv       = (seg != '0) ? seg - 1'b1 : (closed_i ? last_idx : '0);
  assign s1       = seg_nx ? seg_p1[IDX_W-1:0] : '0;
  assign s1_p1    = {1'b0, s1} + 1'b1;
  assign nx1      = (s1_p1 < total_q) ? s1_p1[IDX_W-1:0] : (closed_i ? '0 : last_idx);
  assign pv1      = (s1 != '0) ? s1 - 1'b1 : (closed_i ? last_idx : '0);

  // Hermite coefficients for the current axis
  logic signed [H_W-1:0]  p0, p1, ppv, pnx1, ppv1, d0, d1, dp, a3, a2, mop, pos;
  logic signed [MP_W-1:0] mprod, sh16, sh17;
  logic [31:0]            pos_sat;
  assign p0   = H_W'($signed(pts_q[RS_P0][32*cmd_i.axis +: 32]));
  assign p1   = H_W'($signed(pts_q[RS_P1][32*cmd_i.axis +: 32]));
  assign ppv  = H_W'($signed(pts_q[RS_PV][32*cmd_i.axis +: 32]));
  assign pnx1 = H_W'($signed(pts_q[RS_NX1][32*cmd_i.axis +: 32]));
  assign ppv1 = H_W'($signed(pts_q[RS_PV1][32*cmd_i.axis +: 32]));
  assign d0   = p1 - ppv;
  assign d1   = pnx1 - ppv1;
  assign dp   = p1 - p0;
  assign a3   = (p0 <<< 2) - (p1 <<< 2) + d0 + d1;
  assign a2   = (dp <<< 2) + (dp <<< 1) - (d0 <<< 1) - d1;
  assign mop  = (cmd_i.phase == PH_A3) ? a3 : h_q;
  assign mprod = MP_W'(mop) * MP_W'($signed({1'b0, f_q}));
  assign sh16 = mprod >>> 16;
  assign sh17 = mprod >>> 17;
  assign pos  = p0 + sh17[H_W-1:0];

  // Saturate to int32
  always_comb begin
    if (pos[H_W-1:31] == '0 || pos[H_W-1:31] == '1) begin
      pos_sat = pos[31:0];
    end else if (pos[H_W-1]) begin
      pos_sat = 32'h8000_0000;
    end else begin
      pos_sat = 32'h7FFF_FFFF;
    end
  end

  // Track point count and open path length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      open_q  <= '0;
    end else begin
      if (cmd_i.clear_pts) begin
        total_q <= '0;
        open_q  <= '0;
      end else begin
        if (cmd_i.wr_point) begin
          total_q <= total_q + 1'b1;
        end
        if (cmd_i.acc_chord) begin
          open_q <= open_q + OPEN_W'(root_q);
        end
      end
    end
  end

  // Point store
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_point) begin
      mem[total_q[IDX_W-1:0]] <= in_pt;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[addr_q[cmd_i.rd_sel]];
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      in_q <= in_req_i;
    end
    if (cmd_i.wr_point) begin
      last_q <= in_pt;
      if (total_q == '0) begin
        first_q <= in_pt;
      end
    end
    if (cmd_i.sq_clr) begin
      sumsq_q <= '0;
      rem_q   <= '0;
      root_q  <= '0;
    end else if (cmd_i.sq_step) begin
      sumsq_q <= sumsq_q + SQ_W'(sq);
    end else if (cmd_i.sqrt_step) begin
      sumsq_q <= sumsq_q << 2;
      if (rtry >= rtrial) begin
        rem_q  <= REM_W'(rtry - rtrial);
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rtry[REM_W-1:0];
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd_i.len_load) begin
      len_q <= {1'b0, open_q} + (closed_i ? LEN_W'(root_q) : '0);
    end
    if (cmd_i.mul_ts) begin
      ts_q <= TS_W'(in_q.eval_time) * TS_W'(speed_i);
    end
    if (cmd_i.mul_n) begin
      prod_q <= PROD_W'(ts_q) * PROD_W'(total_q);
      drem_q <= '0;
      qm_q   <= '0;
    end else if (cmd_i.div_step) begin
      prod_q <= prod_q << 1;
      drem_q <= drem_n;
      qm_q   <= (qtry >= {1'b0, modulus}) ? MOD_W'(qtry - {1'b0, modulus})
                                           : qtry[MOD_W-1:0];
    end
    if (cmd_i.idx_calc) begin
      f_q            <= qm_q[FRAC_W-1:0];
      addr_q[RS_P0]  <= seg;
      addr_q[RS_P1]  <= nx;
      addr_q[RS_PV]  <= pv;
      addr_q[RS_NX1] <= nx1;
      addr_q[RS_PV1] <= pv1;
    end
    if (cmd_i.cap_en) begin
      pts_q[cmd_i.cap_sel] <= rdata_q;
    end
    if (cmd_i.herm_step) begin
      case (cmd_i.phase)
        PH_A3:   h_q <= sh16[H_W-1:0] + a2;
        PH_A2:   h_q <= sh16[H_W-1:0] + d0;
        default: res_q[cmd_i.axis] <= pos_sat;
      endcase
    end
    if (cmd_i.out_load) begin
      if (cmd_i.out_empty) begin
        out_q <= '{pos_x: '0, pos_y: '0, pos_z: '0, empty_path: 1'b1};
      end else begin
        out_q <= '{pos_x: res_q[0], pos_y: res_q[1], pos_z: res_q[2], empty_path: 1'b0};
      end
    end
  end

`ifndef ASSERT_OFF
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TOT_W'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_seg_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.idx_calc |-> (qm_q < modulus))
    else $error("segment position beyond point count");

  a_append_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_point |-> (total_q < TOT_W'(MAX_POINTS)))
    else $error("append into full store");
`endif

endmodule

// ===== rtl/catmull_rom_path_evaluator.sv =====
// Catmull-Rom path evaluator.
// Requests arrive on in_valid_i / in_stall_o / in_req_i: append a point,
// evaluate at a time, or clear the points. Only evaluate requests give a
// result, on out_valid_o / out_stall_i / out_res_o. A channel moves a
// request at a clock edge where valid is high and stall is low.
// speed and closed_loop are written over the APB port (byte addresses 0
// and 4); the user must write them only while the block is idle, as the
// block does not enforce this. pready is always high.
// One request is processed at a time. Append finds the chord length
// from three squares and a 34-step square root (the first point of a
// path skips it). Evaluate on a closed path first finds the closing
// chord the same way; then the 71-step restoring divider maps the time,
// five point-store reads and nine steps of the shared multiplier follow.
// The result sits in an output register, so a new request is taken while
// a result waits; a stalled result holds until taken and the next
// evaluate waits at its end for it.
// Reset empties the path, sets speed to 1.0 and the path open.
module catmull_rom_path_evaluator import crpe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_req_t           in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_res_t          out_res_o
);

  logic [31:0] speed_q;
  logic        closed_q;
  cmd_t        cmd;
  sts_t        sts;

  assign pready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q  <= SPEED_RESET;
      closed_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_SPEED:  speed_q  <= pwdata;
        REG_CLOSED: closed_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back configuration
  always_comb begin
    unique case (paddr[2])
      REG_SPEED:  prdata = speed_q;
      REG_CLOSED: prdata = {31'b0, closed_q};
      default:    prdata = '0;
    endcase
  end

  crpe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .closed_i    (closed_q),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  crpe_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .in_req_i  (in_req_i),
    .speed_i   (speed_q),
    .closed_i  (closed_q),
    .out_res_o (out_res_o)
  );

endmodule

// ===== tb/catmull_rom_path_evaluator_test.sv =====
`timescale 1ns / 1ps

module catmull_rom_path_evaluator_test import crpe_pkg::*; ();

  localparam logic [ADDR_W-1:0] ADDR_SPEED  = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_CLOSED = 3'd4;
  localparam logic [1:0]        OP_NONE     = 2'd3;
  localparam int                CYCLE_LIMIT = 1500000;
  localparam int                LONG_HOLD   = 400;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  in_req_t           in_req_i = '0;
  logic              out_valid_o;
  logic              rx_stall = 1'b0;
  out_res_t          out_res_o;

  // Path state mirrored from the requests the block accepts
  logic [31:0]        path_speed;
  logic               path_closed;
  logic signed [31:0] path_pts [MAX_POINTS][3];
  int                 path_count;
  logic [47:0]        path_open_len;

  in_req_t  pending_reqs[$];
  out_res_t expected_pos[$];
  int       mismatch_cnt = 0;
  int       cycle_cnt = 0;
  int       tx_gap = 0;
  int       rx_wait = 0;
  int       rx_hold_left = 0;
  bit       rx_hold_arm = 1'b0;
  bit       tx_pause = 1'b0;
  bit       no_idle = 1'b0;
  bit       req_taken = 1'b0;
  bit       res_taken = 1'b0;

  always #4 clk_i = ~clk_i;

  catmull_rom_path_evaluator dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .in_req_i,
    .out_valid_o, .out_stall_i(rx_stall || rx_hold_left != 0), .out_res_o
  );

  // Exact integer square root of a 68-bit sum of squares
  function automatic logic [33:0] isqrt68(input logic [67:0] v);
    logic [71:0] r;
    logic [71:0] trial;
    logic [33:0] q;
    r = '0;
    q = '0;
    for (int k = 33; k >= 0; k--) begin
      r = (r << 2) | v[2*k +: 2];
      trial = ({38'd0, q} << 2) | 72'd1;
      if (r >= trial) begin
        r = r - trial;
        q = (q << 1) | 34'd1;
      end else begin
        q = q << 1;
      end
    end
    return q;
  endfunction

  function automatic logic [33:0] chord_between(input int a, input int b);
    logic [67:0] sum;
    logic [67:0] m;
    longint d;
    sum = '0;
    for (int c = 0; c < 3; c++) begin
      d = longint'(path_pts[b][c]) - longint'(path_pts[a][c]);
      m = (d < 0) ? 68'(-d) : 68'(d);
      sum = sum + m * m;
    end
    return isqrt68(sum);
  endfunction

  function automatic int prev_pt(input int j, input int n);
    if (j > 0) return j - 1;
    return path_closed ? n - 1 : 0;
  endfunction

  function automatic int next_pt(input int j, input int n);
    if (j + 1 < n) return j + 1;
    return path_closed ? 0 : n - 1;
  endfunction

  // Position on the path for one evaluate request
  function automatic out_res_t path_position(input logic [31:0] t);
    out_res_t res;
    logic [48:0] len;
    logic [127:0] prod;
    logic [127:0] q;
    int n, seg, nx, s1;
    longint frac, p0, p1, d0, d1, a3, a2, h, pos;
    res = '0;
    res.empty_path = 1'b1;
    n = path_count;
    if (n == 0) return res;
    len = {1'b0, path_open_len};
    if (path_closed) len = len + chord_between(n - 1, 0);
    if (len == 0) return res;
    prod = 128'(t) * 128'(path_speed) * 128'(n);
    q = (prod / 128'(len)) % (128'(n) << 16);
    seg = int'(q >> 16);
    frac = longint'(q[15:0]);
    nx = next_pt(seg, n);
    s1 = (seg + 1 < n) ? seg + 1 : 0;
    for (int c = 0; c < 3; c++) begin
      p0 = path_pts[seg][c];
      p1 = path_pts[nx][c];
      d0 = longint'(path_pts[next_pt(seg, n)][c]) - longint'(path_pts[prev_pt(seg, n)][c]);
      d1 = longint'(path_pts[next_pt(s1, n)][c]) - longint'(path_pts[prev_pt(s1, n)][c]);
      a3 = 4 * p0 - 4 * p1 + d0 + d1;
      a2 = -6 * p0 + 6 * p1 - 2 * d0 - d1;
      h = ((a3 * frac) >>> 16) + a2;
      h = ((h * frac) >>> 16) + d0;
      pos = p0 + ((h * frac) >>> 17);
      if (pos > 64'sh7FFF_FFFF) pos = 64'sh7FFF_FFFF;
      if (pos < -64'sh8000_0000) pos = -64'sh8000_0000;
      case (c)
        0: res.pos_x = pos[31:0];
        1: res.pos_y = pos[31:0];
        default: res.pos_z = pos[31:0];
      endcase
    end
    res.empty_path = 1'b0;
    return res;
  endfunction

  // Update the path mirror for one accepted request
  function automatic void apply_request(input in_req_t r);
    case (r.opcode)
      OP_APPEND: begin
        if (path_count < MAX_POINTS) begin
          path_pts[path_count][0] = r.point_x;
          path_pts[path_count][1] = r.point_y;
          path_pts[path_count][2] = r.point_z;
          if (path_count > 0)
            path_open_len = path_open_len + 48'(chord_between(path_count - 1, path_count));
          path_count++;
        end
      end
      OP_EVAL:  expected_pos = {expected_pos, path_position(r.eval_time)};
      OP_CLEAR: begin
        path_count = 0;
        path_open_len = '0;
      end
      default: ;
    endcase
  endfunction

  // Track handshakes, predict, and check results at the rising edge
  always @(posedge clk_i) begin
    out_res_t want;
    req_taken <= in_valid_i && !in_stall_o;
    res_taken <= out_valid_o && !(rx_stall || rx_hold_left != 0);
    if (rst_ni && in_valid_i && !in_stall_o) apply_request(in_req_i);
    if (rst_ni && out_valid_o && !(rx_stall || rx_hold_left != 0)) begin
      if (expected_pos.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected position %p", out_res_o);
      end else begin
        want = expected_pos.pop_front();
        if (out_res_o.pos_x !== want.pos_x || out_res_o.pos_y !== want.pos_y ||
            out_res_o.pos_z !== want.pos_z || out_res_o.empty_path !== want.empty_path) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("position mismatch: expected %p, got %p", want, out_res_o);
        end
      end
    end
  end

  // Offer requests; hold a stalled request, then wait out the drawn gap
  always @(negedge clk_i) begin
    if (in_valid_i && !req_taken) begin
    end else if (tx_gap > 0) begin
      in_valid_i <= 1'b0;
      tx_gap <= tx_gap - 1;
    end else if (rst_ni && !tx_pause && pending_reqs.size() > 0) begin
      in_req_i <= pending_reqs.pop_front();
      in_valid_i <= 1'b1;
      tx_gap <= no_idle ? 0 : $urandom_range(0, 19);
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Stall results for a drawn number of cycles after each one is taken
  always @(negedge clk_i) begin
    int wait_draw;
    if (res_taken) begin
      wait_draw = no_idle ? 0 : $urandom_range(0, 19);
      rx_wait <= (wait_draw > 0) ? wait_draw - 1 : 0;
      rx_stall <= (wait_draw > 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      rx_stall <= 1'b1;
    end else begin
      rx_stall <= 1'b0;
    end
  end

  // Long receiver hold-off so the block backs up into its input
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) rx_hold_left <= rx_hold_left - 1;
    else if (rx_hold_arm) rx_hold_left <= LONG_HOLD;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[catmull_rom_path_evaluator] ERROR");
      $finish;
    end
  end

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == ADDR_SPEED) path_speed = data;
    else path_closed = data[0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Drain all requests and results, then let a trailing append finish
  task automatic wait_quiet();
    while (pending_reqs.size() != 0 || in_valid_i || expected_pos.size() != 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic push_req(input logic [1:0] op, input logic [31:0] x, input logic [31:0] y,
                          input logic [31:0] z, input logic [31:0] t);
    in_req_t r;
    r.opcode = op;
    r.point_x = x;
    r.point_y = y;
    r.point_z = z;
    r.eval_time = t;
    pending_reqs = {pending_reqs, r};
  endtask

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 2) == 0) return $urandom;
    return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
  endfunction

  function automatic logic [31:0] rand_time();
    case ($urandom_range(0, 2))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0010_0000);
      default: return $urandom_range(0, 32'h0000_FFFF);
    endcase
  endfunction

  // Mostly well-formed paths: optional clear, appends, then evaluations
  task automatic add_paths(input int count);
    int added;
    int k;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 9) == 0) begin
        push_req(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
        added++;
      end else begin
        if ($urandom_range(0, 2) != 0) begin
          push_req(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
          added++;
        end
        k = $urandom_range(2, 7);
        for (int i = 0; i < k; i++)
          push_req(OP_APPEND, rand_coord(), rand_coord(), rand_coord(), $urandom);
        added += k;
        k = $urandom_range(2, 6);
        for (int i = 0; i < k; i++)
          push_req(OP_EVAL, $urandom, $urandom, $urandom, rand_time());
        added += k;
      end
    end
  endtask

  initial begin
    path_speed = SPEED_RESET;
    path_closed = 1'b0;
    path_count = 0;
    path_open_len = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: unused opcode, empty path, coinciding points, extremes
    push_req(OP_NONE, '1, '1, '1, '1);
    push_req(OP_CLEAR, '0, '0, '0, '0);
    push_req(OP_EVAL, '0, '0, '0, 32'h0001_0000);
    push_req(OP_APPEND, 32'h0001_0000, 32'h0002_0000, '0, '0);
    push_req(OP_EVAL, '0, '0, '0, 32'h0000_8000);
    push_req(OP_APPEND, 32'h0001_0000, 32'h0002_0000, '0, '0);
    push_req(OP_EVAL, '0, '0, '0, 32'h0000_8000);
    push_req(OP_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
    push_req(OP_APPEND, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0);
    push_req(OP_APPEND, '0, 32'h7FFF_FFFF, 32'h8000_0000, '0);
    push_req(OP_EVAL, '1, '1, '1, '0);
    push_req(OP_EVAL, '0, '0, '0, '1);
    push_req(OP_EVAL, '0, '0, '0, 32'h0000_4000);
    push_req(OP_EVAL, '0, '0, '0, 32'h0003_0000);
    push_req(OP_CLEAR, '1, '1, '1, '1);
    push_req(OP_EVAL, '0, '0, '0, '1);
    wait_quiet();

    // Closed loop at top speed over an extreme path
    apb_write(ADDR_SPEED, 32'hFFFF_FFFF);
    apb_write(ADDR_CLOSED, 32'd1);
    push_req(OP_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0);
    push_req(OP_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0);
    push_req(OP_APPEND, '0, '0, 32'h7FFF_FFFF, '0);
    push_req(OP_EVAL, '0, '0, '0, '1);
    push_req(OP_EVAL, '0, '0, '0, 32'h0000_0001);
    add_paths(120);
    wait_quiet();

    // Zero speed, open path; fill the store past its capacity
    apb_write(ADDR_SPEED, 32'd0);
    apb_write(ADDR_CLOSED, 32'd0);
    push_req(OP_CLEAR, '0, '0, '0, '0);
    for (int i = 0; i < MAX_POINTS + 6; i++)
      push_req(OP_APPEND, rand_coord(), rand_coord(), rand_coord(), '0);
    push_req(OP_EVAL, '0, '0, '0, $urandom);
    wait_quiet();
    apb_write(ADDR_SPEED, 32'h0000_0100);
    repeat (20) push_req(OP_EVAL, '0, '0, '0, $urandom);
    wait_quiet();

    // Random speed, closed loop, receiver holds off for a long stretch
    apb_write(ADDR_SPEED, $urandom);
    apb_write(ADDR_CLOSED, 32'd1);
    add_paths(130);
    rx_hold_arm = 1'b1;
    while (rx_hold_left == 0) @(posedge clk_i);
    rx_hold_arm = 1'b0;
    wait_quiet();

    // Unit speed, open path, with a sender pause until results drain
    apb_write(ADDR_SPEED, SPEED_RESET);
    apb_write(ADDR_CLOSED, 32'd0);
    add_paths(130);
    while (pending_reqs.size() > 60) @(posedge clk_i);
    tx_pause = 1'b1;
    while (expected_pos.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    tx_pause = 1'b0;
    wait_quiet();

    // Back-to-back traffic with no idling on either side
    no_idle = 1'b1;
    apb_write(ADDR_SPEED, $urandom_range(1, 32'h0004_0000));
    apb_write(ADDR_CLOSED, 32'd1);
    add_paths(130);
    wait_quiet();
    no_idle = 1'b0;

    apb_write(ADDR_SPEED, $urandom);
    apb_write(ADDR_CLOSED, 32'd0);
    add_paths(160);
    wait_quiet();

    if (mismatch_cnt == 0) begin
      $display("[catmull_rom_path_evaluator] OK");
    end else begin
      $display("[catmull_rom_path_evaluator] ERROR");
    end
    $finish;
  end

endmodule
